FILE: rtl/u8ot_pkg.sv
// Shared constants and types for the oversampled 8N1 UART transceiver.
package u8ot_pkg;

   localparam int OVERSAMPLE = 3;
   localparam int FIFO_DEPTH = 16;
   localparam int DATA_BITS  = 8;
   localparam int STOP_POS   = DATA_BITS + 1;

   localparam int PHASE_W = $clog2(OVERSAMPLE + 1);
   localparam int POS_W   = $clog2(STOP_POS + 2);
   localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);

   localparam int RX_START_DELAY = ((OVERSAMPLE / 2) == 0) ? 1 : (OVERSAMPLE / 2);

   localparam int REQ_W = 16;
   localparam int RSP_W = 24;

   typedef logic [PHASE_W-1:0]   phase_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [PTR_W-1:0]     ptr_type;
   typedef logic [FILL_W-1:0]    fill_type;
   typedef logic [DATA_BITS-1:0] byte_type;

   typedef struct packed {
      logic line;
      logic active;
      logic taken;
   } tx_status_type;

   typedef struct packed {
      logic     valid;
      byte_type data;
   } rx_push_type;

   typedef struct packed {
      logic     valid;
      byte_type data;
      fill_type fill;
   } fifo_status_type;

endpackage

FILE: rtl/uart_8n1_oversampled_transceiver.sv
// Top level of the oversampled 8N1 UART transceiver with receive FIFO.
//
// Each request transaction is one oversample tick. It carries the sampled
// receive line level, an optional transmit byte load and an optional pop of
// the receive FIFO. Every request produces exactly one response transaction
// with the transmit line level, transmitter activity, the load and pop
// outcomes, the popped byte and the FIFO fill after the tick.
// All state advances in the cycle a request is accepted and the response is
// captured in an output register, so a request can be taken in every cycle
// while the response side keeps up: one tick per cycle sustained.
// The output register is the only buffer. A request is accepted while the
// register is empty or its contents are being taken in the same cycle, so
// when the response side stalls, the request side stalls with it and no
// response is lost or duplicated.
// Synchronous reset returns the transmitter and receiver to idle, drives
// the transmit line high, empties the FIFO and clears the response valid.
module uart_8n1_oversampled_transceiver (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // rx_level[0], tx_load[1], tx_byte[9:2], rx_pop[10], zero fill above
   input  logic [u8ot_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tx_line[0], tx_active[1], load_taken[2], popped_byte[10:3], pop_valid[11],
   // fifo_fill[16:12], zero fill above
   output logic [u8ot_pkg::RSP_W-1:0] rsp_tdata
);

   logic                      step;
   logic                      rx_level;
   logic                      tx_load;
   u8ot_pkg::byte_type        tx_byte;
   logic                      rx_pop;
   u8ot_pkg::tx_status_type   tx_status;
   u8ot_pkg::rx_push_type     rx_push;
   u8ot_pkg::fifo_status_type fifo_status;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [u8ot_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign rx_level   = req_tdata[0];
   assign tx_load    = req_tdata[1];
   assign tx_byte    = req_tdata[9:2];
   assign rx_pop     = req_tdata[10];
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign step       = req_tvalid & req_tready;

   u8ot_tx u_tx (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .tx_load (tx_load),
      .tx_byte (tx_byte),
      .status  (tx_status)
   );

   u8ot_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_level (rx_level),
      .push     (rx_push)
   );

   u8ot_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .rx_pop (rx_pop),
      .push   (rx_push),
      .status (fifo_status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_data_in = {7'b0, fifo_status.fill, fifo_status.valid, fifo_status.data,
                     tx_status.taken, tx_status.active, tx_status.line};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/u8ot_tx.sv
// Transmitter: start bit, eight data bits least significant first, stop bit.
module u8ot_tx (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   tx_load,
   input  u8ot_pkg::byte_type     tx_byte,
   output u8ot_pkg::tx_status_type status
);

   logic                running_ff, running_in;
   u8ot_pkg::byte_type  shifter_ff, shifter_in;
   u8ot_pkg::pos_type   pos_ff, pos_in;
   u8ot_pkg::phase_type phase_ff, phase_in;
   logic                pin_ff, pin_in;

   logic                taken;
   logic                run0;
   u8ot_pkg::byte_type  sh0;
   u8ot_pkg::pos_type   pos0;
   u8ot_pkg::phase_type ph0;
   u8ot_pkg::phase_type ph1;
   u8ot_pkg::pos_type   pos1;

   always_comb begin
      taken      = tx_load & ~running_ff;
      run0       = running_ff | taken;
      sh0        = taken ? tx_byte : shifter_ff;
      pos0       = taken ? '0 : pos_ff;
      ph0        = taken ? '0 : phase_ff;
      running_in = run0;
      shifter_in = sh0;
      pos_in     = pos0;
      phase_in   = ph0;
      pin_in     = pin_ff;
      ph1        = ph0 + u8ot_pkg::phase_type'(1);
      pos1       = pos0 + u8ot_pkg::pos_type'(1);
      if (run0) begin
         if (ph0 == '0) begin
            if (pos0 == '0) begin
               pin_in = 1'b0;
            end else if (pos0 <= u8ot_pkg::pos_type'(u8ot_pkg::DATA_BITS)) begin
               pin_in     = sh0[0];
               shifter_in = sh0 >> 1;
            end else begin
               pin_in = 1'b1;
            end
         end
         if (ph1 >= u8ot_pkg::phase_type'(u8ot_pkg::OVERSAMPLE)) begin
            phase_in = '0;
            pos_in   = pos1;
            if (pos1 > u8ot_pkg::pos_type'(u8ot_pkg::STOP_POS)) begin
               running_in = 1'b0;
               pos_in     = '0;
               pin_in     = 1'b1;
            end
         end else begin
            phase_in = ph1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         shifter_ff <= '0;
         pos_ff     <= '0;
         phase_ff   <= '0;
         pin_ff     <= 1'b1;
      end else if (step) begin
         running_ff <= running_in;
         shifter_ff <= shifter_in;
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         pin_ff     <= pin_in;
      end
   end

   assign status.line   = pin_in;
   assign status.active = running_in;
   assign status.taken  = taken;

endmodule

FILE: rtl/u8ot_rx.sv
// Receiver: start detection, centre sampling of data and stop bits.
module u8ot_rx (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  rx_level,
   output u8ot_pkg::rx_push_type push
);

   logic                running_ff, running_in;
   u8ot_pkg::byte_type  shifter_ff, shifter_in;
   u8ot_pkg::pos_type   pos_ff, pos_in;
   u8ot_pkg::phase_type phase_ff, phase_in;
   u8ot_pkg::phase_type ph_dec;

   always_comb begin
      running_in = running_ff;
      shifter_in = shifter_ff;
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      push.valid = 1'b0;
      push.data  = shifter_ff;
      ph_dec     = (phase_ff != '0) ? phase_ff - u8ot_pkg::phase_type'(1) : phase_ff;
      if (!running_ff) begin
         if (!rx_level) begin
            running_in = 1'b1;
            pos_in     = '0;
            shifter_in = '0;
            phase_in   = u8ot_pkg::phase_type'(u8ot_pkg::RX_START_DELAY);
         end
      end else begin
         phase_in = ph_dec;
         if (ph_dec == '0) begin
            phase_in = u8ot_pkg::phase_type'(u8ot_pkg::OVERSAMPLE);
            if (pos_ff == '0) begin
               if (rx_level) begin
                  running_in = 1'b0;
               end else begin
                  pos_in = u8ot_pkg::pos_type'(1);
               end
            end else if (pos_ff <= u8ot_pkg::pos_type'(u8ot_pkg::DATA_BITS)) begin
               shifter_in = {rx_level, shifter_ff[u8ot_pkg::DATA_BITS-1:1]};
               pos_in     = pos_ff + u8ot_pkg::pos_type'(1);
            end else begin
               push.valid = rx_level;
               running_in = 1'b0;
               pos_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         shifter_ff <= '0;
         pos_ff     <= '0;
         phase_ff   <= '0;
      end else if (step) begin
         running_ff <= running_in;
         shifter_ff <= shifter_in;
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

FILE: rtl/u8ot_fifo.sv
// Receive FIFO: pop is served before the push of the same transaction.
module u8ot_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      rx_pop,
   input  u8ot_pkg::rx_push_type     push,
   output u8ot_pkg::fifo_status_type status
);

   u8ot_pkg::byte_type store_ff [u8ot_pkg::FIFO_DEPTH];
   u8ot_pkg::ptr_type  wr_ptr_ff, wr_ptr_in;
   u8ot_pkg::ptr_type  rd_ptr_ff, rd_ptr_in;
   u8ot_pkg::fill_type fill_ff, fill_in;

   logic               pop_ok;
   logic               push_ok;
   u8ot_pkg::fill_type fill_mid;

   function automatic u8ot_pkg::ptr_type next_ptr(input u8ot_pkg::ptr_type p);
      u8ot_pkg::ptr_type last;
      last = u8ot_pkg::ptr_type'(u8ot_pkg::FIFO_DEPTH - 1);
      return (p == last) ? '0 : p + u8ot_pkg::ptr_type'(1);
   endfunction

   always_comb begin
      pop_ok    = rx_pop & (fill_ff != '0);
      fill_mid  = pop_ok ? fill_ff - u8ot_pkg::fill_type'(1) : fill_ff;
      push_ok   = push.valid & (fill_mid < u8ot_pkg::fill_type'(u8ot_pkg::FIFO_DEPTH));
      fill_in   = push_ok ? fill_mid + u8ot_pkg::fill_type'(1) : fill_mid;
      rd_ptr_in = pop_ok ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = push_ok ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else if (step) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && push_ok) begin
         store_ff[wr_ptr_ff] <= push.data;
      end
   end

   assign status.valid = pop_ok;
   assign status.data  = pop_ok ? store_ff[rd_ptr_ff] : '0;
   assign status.fill  = fill_in;

endmodule

FILE: tb/uart_tick_checker.sv
// Checker that predicts each response transaction of the UART transceiver and compares it.
`timescale 1ns / 100ps
module uart_tick_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   // rx_level[0], tx_load[1], tx_byte[9:2], rx_pop[10], zero fill above
   input  logic [u8ot_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tx_line[0], tx_active[1], load_taken[2], popped_byte[10:3], pop_valid[11],
   // fifo_fill[16:12], zero fill above
   input  logic [u8ot_pkg::RSP_W-1:0] rsp_tdata,
   output int                         mismatches,
   output int                         outstanding,
   output int                         fifo_level,
   output int                         full_drops,
   output int                         bytes_stored,
   output int                         loads_taken
);

   typedef struct packed {
      logic               line;
      logic               active;
      logic               taken;
      u8ot_pkg::byte_type popped;
      logic               popped_ok;
      u8ot_pkg::fill_type fill;
   } tick_status_type;

   logic                txr_busy;
   u8ot_pkg::byte_type  txr_shift;
   u8ot_pkg::pos_type   txr_slot;
   u8ot_pkg::phase_type txr_tick;
   logic                txr_pin;
   logic                rcv_busy;
   u8ot_pkg::byte_type  rcv_shift;
   u8ot_pkg::pos_type   rcv_slot;
   u8ot_pkg::phase_type rcv_wait;
   u8ot_pkg::byte_type  rx_fifo [u8ot_pkg::FIFO_DEPTH];
   u8ot_pkg::ptr_type   wr_idx;
   u8ot_pkg::ptr_type   rd_idx;
   int                  fifo_used;
   tick_status_type     status_q [$];

   function automatic u8ot_pkg::ptr_type wrap_inc(input u8ot_pkg::ptr_type p);
      return (p == u8ot_pkg::ptr_type'(u8ot_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   task automatic advance_tick(input logic level, input logic load,
                               input u8ot_pkg::byte_type data, input logic pop,
                               output tick_status_type st);
      st = '0;
      if (pop && fifo_used > 0) begin
         st.popped    = rx_fifo[rd_idx];
         st.popped_ok = 1'b1;
         rd_idx       = wrap_inc(rd_idx);
         fifo_used--;
      end

      if (load && !txr_busy) begin
         txr_shift = data;
         txr_slot  = '0;
         txr_tick  = '0;
         txr_busy  = 1'b1;
         st.taken  = 1'b1;
         loads_taken++;
      end

      if (txr_busy) begin
         if (txr_tick == 0) begin
            if (txr_slot == 0) begin
               txr_pin = 1'b0;
            end else if (txr_slot <= u8ot_pkg::DATA_BITS) begin
               txr_pin   = txr_shift[0];
               txr_shift = txr_shift >> 1;
            end else begin
               txr_pin = 1'b1;
            end
         end
         if (txr_tick == u8ot_pkg::phase_type'(u8ot_pkg::OVERSAMPLE - 1)) begin
            txr_tick = '0;
            txr_slot = txr_slot + 1'b1;
            if (txr_slot > u8ot_pkg::STOP_POS) begin
               txr_busy = 1'b0;
               txr_slot = '0;
               txr_pin  = 1'b1;
            end
         end else begin
            txr_tick = txr_tick + 1'b1;
         end
      end

      if (!rcv_busy) begin
         if (!level) begin
            rcv_busy  = 1'b1;
            rcv_slot  = '0;
            rcv_shift = '0;
            rcv_wait  = u8ot_pkg::phase_type'(u8ot_pkg::RX_START_DELAY);
         end
      end else begin
         if (rcv_wait > 0) rcv_wait = rcv_wait - 1'b1;
         if (rcv_wait == 0) begin
            rcv_wait = u8ot_pkg::phase_type'(u8ot_pkg::OVERSAMPLE);
            if (rcv_slot == 0) begin
               if (level) rcv_busy = 1'b0;
               else rcv_slot = u8ot_pkg::pos_type'(1);
            end else if (rcv_slot <= u8ot_pkg::DATA_BITS) begin
               rcv_shift = {level, rcv_shift[u8ot_pkg::DATA_BITS-1:1]};
               rcv_slot  = rcv_slot + 1'b1;
            end else begin
               if (level && fifo_used < u8ot_pkg::FIFO_DEPTH) begin
                  rx_fifo[wr_idx] = rcv_shift;
                  wr_idx          = wrap_inc(wr_idx);
                  fifo_used++;
                  bytes_stored++;
               end else if (level) begin
                  full_drops++;
               end
               rcv_busy = 1'b0;
               rcv_slot = '0;
            end
         end
      end

      st.line   = txr_pin;
      st.active = txr_busy;
      st.fill   = u8ot_pkg::fill_type'(fifo_used);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tick_status_type want;
      tick_status_type got;
      tick_status_type next_status;
      if (reset) begin
         txr_busy  = 1'b0;
         txr_shift = '0;
         txr_slot  = '0;
         txr_tick  = '0;
         txr_pin   = 1'b1;
         rcv_busy  = 1'b0;
         rcv_shift = '0;
         rcv_slot  = '0;
         rcv_wait  = '0;
         wr_idx    = '0;
         rd_idx    = '0;
         fifo_used = 0;
         status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tdata[10:3], rsp_tdata[11],
                   rsp_tdata[16:12]};
            if (status_q.size() == 0) begin
               $error("Response transaction arrived with no request outstanding.");
               mismatches++;
            end else begin
               want = status_q.pop_front();
               check_field("tx_line", want.line, got.line);
               check_field("tx_active", want.active, got.active);
               check_field("load_taken", want.taken, got.taken);
               check_field("popped_byte", want.popped, got.popped);
               check_field("pop_valid", want.popped_ok, got.popped_ok);
               check_field("fifo_fill", want.fill, got.fill);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_tick(req_tdata[0], req_tdata[1], req_tdata[9:2], req_tdata[10], next_status);
            status_q.push_back(next_status);
         end
      end
      outstanding = status_q.size();
      fifo_level  = fifo_used;
   end

endmodule

FILE: tb/testbench.sv
// Top of the UART transceiver testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps
module testbench;

   localparam int RANDOM_TICKS   = 540;
   localparam int PHASE_TICKS    = 135;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // rx_level[0], tx_load[1], tx_byte[9:2], rx_pop[10], zero fill above
   logic [u8ot_pkg::REQ_W-1:0] req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // tx_line[0], tx_active[1], load_taken[2], popped_byte[10:3], pop_valid[11],
   // fifo_fill[16:12], zero fill above
   logic [u8ot_pkg::RSP_W-1:0] rsp_tdata;

   int         mismatches;
   int         outstanding;
   int         fifo_level;
   int         full_drops;
   int         bytes_stored;
   int         loads_taken;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         load_pct = 0;
   int         pop_pct = 0;
   int         items_sent = 0;
   int         quiet_cycles = 0;
   idling_type idling = IDLE_NONE;

   uart_8n1_oversampled_transceiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   uart_tick_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .fifo_level   (fifo_level),
      .full_drops   (full_drops),
      .bytes_stored (bytes_stored),
      .loads_taken  (loads_taken)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idling(input idling_type mode);
      idling        = mode;
      send_idle_pct = (mode == IDLE_SENDER) ? 65 : (mode == IDLE_BOTH) ? 14 : 0;
      stall_pct     = (mode == IDLE_RECEIVER) ? 65 : (mode == IDLE_BOTH) ? 14 : 0;
   endtask

   task automatic send_tick(input logic level, input logic load,
                            input u8ot_pkg::byte_type data, input logic pop);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, pop, data, load, level};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic line_ticks(input logic level, input int count);
      repeat (count) begin
         send_tick(level, $urandom_range(0, 99) < load_pct,
                   u8ot_pkg::byte_type'($urandom_range(0, 255)),
                   $urandom_range(0, 99) < pop_pct);
      end
   endtask

   task automatic send_frame(input u8ot_pkg::byte_type data, input logic stop_level);
      line_ticks(1'b0, u8ot_pkg::OVERSAMPLE);
      for (int b = 0; b < u8ot_pkg::DATA_BITS; b++) line_ticks(data[b], u8ot_pkg::OVERSAMPLE);
      line_ticks(stop_level, u8ot_pkg::OVERSAMPLE);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   initial begin
      int       random_start;
      int       phase_idx;
      logic     filling;
      logic     stop_level;
      int       load_choice [4];
      int       pop_choice [3];

      load_choice = '{0, 8, 30, 100};
      pop_choice  = '{5, 20, 60};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);
      @(negedge clock);

      send_tick(1'b1, 1'b0, 8'h00, 1'b0);
      send_tick(1'b1, 1'b0, 8'h00, 1'b1);
      send_tick(1'b0, 1'b1, 8'hFF, 1'b1);
      send_tick(1'b1, 1'b1, 8'h00, 1'b0);
      send_tick(1'b1, 1'b0, 8'h00, 1'b0);
      send_tick(1'b0, 1'b1, 8'h5A, 1'b1);
      for (int i = 0; i < 12; i++) send_tick(1'b0, 1'b1, 8'hA5, i[0]);
      repeat (6) send_tick(1'b1, 1'b1, 8'h00, 1'b1);
      wait_for_responses();

      random_start = items_sent;
      filling      = 1'b1;
      while ((items_sent - random_start < RANDOM_TICKS || filling) &&
             items_sent - random_start < 3 * RANDOM_TICKS) begin
         phase_idx = (items_sent - random_start) / PHASE_TICKS;
         if (phase_idx > 3) phase_idx = 3;
         if (idling_type'(phase_idx) != idling) begin
            wait_for_responses();
            set_idling(idling_type'(phase_idx));
         end
         load_pct = load_choice[$urandom_range(0, 3)];
         pop_pct  = filling ? 0 : pop_choice[$urandom_range(0, 2)];
         case ($urandom_range(0, 9))
            0: begin
               if (!filling) begin
                  for (int n = $urandom_range(1, 8); n > 0; n--) begin
                     line_ticks(1'($urandom_range(0, 1)), 1);
                  end
               end
            end
            1: begin
               line_ticks(1'b0, 1);
               line_ticks(1'b1, 2);
            end
            default: begin
            end
         endcase
         stop_level = filling ? 1'b1 : ($urandom_range(0, 3) != 0);
         send_frame(u8ot_pkg::byte_type'($urandom_range(0, 255)), stop_level);
         line_ticks(1'b1, filling ? 0 : $urandom_range(0, 3));
         if (full_drops >= 1) filling = 1'b0;
      end

      wait_for_responses();
      repeat (4) @(negedge clock);
      $display("Covered %0d ticks under four idling phases, %0d frames sent.",
               items_sent, loads_taken);
      $display("Receive FIFO took %0d bytes and dropped %0d while full.",
               bytes_stored, full_drops);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/u8ot_pkg.sv
rtl/u8ot_tx.sv
rtl/u8ot_rx.sv
rtl/u8ot_fifo.sv
rtl/uart_8n1_oversampled_transceiver.sv
tb/uart_tick_checker.sv
tb/testbench.sv
